FILE: rtl/core/circular_array_queue_defines.svh
// Assertion macros for the circular array queue.
`ifndef CIRCULAR_ARRAY_QUEUE_DEFINES_SVH
`define CIRCULAR_ARRAY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define CAQ_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("queue assertion failed");

// Check that a trigger in one cycle is followed by a condition in the next.
`define CAQ_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("queue assertion failed");

`else

`define CAQ_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define CAQ_ASSERT_NEXT(lbl, clk, rst, trig, cond)

`endif

`endif

FILE: rtl/core/caq_pkg.sv
`default_nettype none

package caq_pkg;

   localparam int DEPTH        = 16;
   localparam int WORD_BITS    = 32;
   localparam int IDX_BITS     = $clog2(DEPTH);
   localparam int CNT_BITS     = $clog2(DEPTH + 1);
   localparam int CAP_BITS     = 5;
   localparam int CMD_BITS     = 3;
   localparam int STATUS_BITS  = 2;
   localparam int OCC_BITS     = 5;
   localparam int MIN_CAPACITY = 5;

   localparam logic [CAP_BITS-1:0] CAPACITY_RESET = CAP_BITS'(16);

   // Command codes
   localparam logic [CMD_BITS-1:0] CMD_ENQUEUE     = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_DEQUEUE     = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_PEEK        = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_FRONT_DEQ   = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR       = 3'd4;

   // Status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [CMD_BITS-1:0]         command;
      logic signed [WORD_BITS-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] data_out;
      logic [STATUS_BITS-1:0]      status;
      logic                        is_empty;
      logic                        is_full;
      logic [OCC_BITS-1:0]         occupancy;
   } rsp_type;

   typedef struct packed {
      logic                        en;
      logic [IDX_BITS-1:0]         addr;
      logic signed [WORD_BITS-1:0] data;
   } ram_wr_type;

   // Clamp the capacity register into [MIN_CAPACITY, DEPTH].
   function automatic logic [CNT_BITS-1:0] eff_cap(input logic [CAP_BITS-1:0] c);
      logic [CNT_BITS-1:0] r;
      if (int'(c) < MIN_CAPACITY) begin
         r = CNT_BITS'(MIN_CAPACITY);
      end else if (int'(c) > DEPTH) begin
         r = CNT_BITS'(DEPTH);
      end else begin
         r = CNT_BITS'(c);
      end
      return r;
   endfunction

   // Step an index, wrapping to zero at the effective capacity.
   function automatic logic [IDX_BITS-1:0] advance(input logic [IDX_BITS-1:0] idx,
                                                   input logic [CNT_BITS-1:0] cap);
      logic [CNT_BITS-1:0] n;
      n = CNT_BITS'(idx) + CNT_BITS'(1);
      if (n >= cap) begin
         n = '0;
      end
      return IDX_BITS'(n);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/caq_ram.sv
`default_nettype none

module caq_ram
   import caq_pkg::*;
(
   input  wire logic                        clock,
   input  wire ram_wr_type                  wr,
   input  wire logic                        rd_en,
   input  wire logic [IDX_BITS-1:0]         rd_addr,
   output      logic signed [WORD_BITS-1:0] rd_data
);

   logic signed [WORD_BITS-1:0] mem [DEPTH];
   logic signed [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Hold read data until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/circular_array_queue.sv
// Channel  | Ports                              | Moves
// ---------+------------------------------------+--------------------------------
// request  | req_valid, req_stall, req_item     | one command item in
// response | rsp_valid, rsp_stall, rsp_item     | one result item out per command
// config   | csr_wr_en, csr_wr_data             | capacity register write
//
// Cycles: one item per cycle while the result side keeps up; every command
// settles indices and count in its accept cycle while the store reads at head.
// Path: an accepted item passes the memory read and read stage, then the output
// register, where it raises rsp_valid.
// Reset: synchronous, active high; stored words are not cleared.
// Stalls: req_stall is high only while both stages hold items and rsp_stall is high, and in reset.
`default_nettype none

`include "circular_array_queue_defines.svh"

module circular_array_queue
   import caq_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire req_type             req_item,

   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      rsp_type             rsp_item,

   input  wire logic                csr_wr_en,
   input  wire logic [CAP_BITS-1:0] csr_wr_data
);

   // Queue control state
   logic [CAP_BITS-1:0] capacity_ff;
   logic [IDX_BITS-1:0] head_ff, head_in;
   logic [IDX_BITS-1:0] tail_ff, tail_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   // Read stage: item waiting for memory read data
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_rd_ff, s1_rd_in;
   rsp_type             s1_rsp_ff, s1_rsp_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_item_ff, rsp_item_in;

   logic                accept;
   logic                s1_move;
   logic [CNT_BITS-1:0] cap;
   logic                full_now;
   logic                empty_now;
   logic                enq_ok;
   logic                deq_ok;
   ram_wr_type          ram_wr;
   logic signed [WORD_BITS-1:0] ram_rd_data;

   // Handshake: the read stage drains whenever the output register is free
   // or being taken; hold new items only while the read stage cannot drain.
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = reset || (s1_valid_ff && !s1_move);
   assign accept    = req_valid && !req_stall;

   assign cap       = eff_cap(capacity_ff);
   assign full_now  = (count_ff >= cap);
   assign empty_now = (count_ff == '0);

   // Command decode and state update, all settled in the accept cycle.
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      s1_rd_in  = 1'b0;
      s1_rsp_in = '0;
      ram_wr    = '0;
      enq_ok    = 1'b0;
      deq_ok    = 1'b0;

      if (accept) begin
         unique case (req_item.command)
            CMD_ENQUEUE: begin
               if (full_now) begin
                  s1_rsp_in.status = STATUS_FULL;
               end else begin
                  // Advance tail first, then store at the new tail.
                  enq_ok      = 1'b1;
                  tail_in     = advance(tail_ff, cap);
                  count_in    = count_ff + CNT_BITS'(1);
                  ram_wr.en   = 1'b1;
                  ram_wr.addr = tail_in;
                  ram_wr.data = req_item.data_in;
               end
            end
            CMD_DEQUEUE, CMD_FRONT_DEQ: begin
               if (empty_now) begin
                  s1_rsp_in.status = STATUS_EMPTY;
                  if (req_item.command == CMD_FRONT_DEQ) begin
                     s1_rsp_in.data_out = '1;
                  end
               end else begin
                  // Front word comes from the memory read issued this cycle.
                  deq_ok   = 1'b1;
                  s1_rd_in = (req_item.command == CMD_FRONT_DEQ);
                  head_in  = advance(head_ff, cap);
                  count_in = count_ff - CNT_BITS'(1);
               end
            end
            CMD_PEEK: begin
               if (empty_now) begin
                  s1_rsp_in.status   = STATUS_EMPTY;
                  s1_rsp_in.data_out = '1;
               end else begin
                  s1_rd_in = 1'b1;
               end
            end
            CMD_CLEAR: begin
               // Drop all words; slot contents stay as they are.
               head_in  = IDX_BITS'(1);
               tail_in  = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase

         s1_rsp_in.is_empty  = (count_in == '0);
         s1_rsp_in.is_full   = (count_in >= cap);
         s1_rsp_in.occupancy = OCC_BITS'(count_in);
      end
   end

   // Word store: read at head on every accepted item.
   caq_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // Pipeline control
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = s1_rsp_ff;
         if (s1_rd_ff) begin
            rsp_item_in.data_out = ram_rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         head_ff      <= IDX_BITS'(1);
         tail_ff      <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rd_ff  <= s1_rd_in;
         s1_rsp_ff <= s1_rsp_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Count never leaves the storage range.
   `CAQ_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CNT_BITS'(DEPTH))
   // A stored word raises the count by exactly one.
   `CAQ_ASSERT_NEXT(a_enq_count, clock, reset, enq_ok, count_ff == $past(count_ff) + CNT_BITS'(1))
   // A removed word lowers the count by exactly one.
   `CAQ_ASSERT_NEXT(a_deq_count, clock, reset, deq_ok, count_ff == $past(count_ff) - CNT_BITS'(1))
   // An item in the read stage with a free output register reaches the output.
   `CAQ_ASSERT_NEXT(a_s1_drain, clock, reset, s1_valid_ff && !rsp_valid_ff, rsp_valid_ff)

endmodule

`default_nettype wire
